// ===== sv/frd_pkg.sv =====
`default_nettype none

package frd_pkg;

  // status of the serial divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } frd_div_sts_t;

endpackage : frd_pkg

`default_nettype wire

// ===== sv/frd_div.sv =====
`default_nettype none

module frd_div
  import frd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output frd_div_sts_t          sts_o,
  output logic      [WIDTH-1:0] quotient_o
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // one quotient bit per cycle, restoring form
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(WIDTH - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule : frd_div

`default_nettype wire

// ===== sv/fraction_reduce_gcd_unit.sv =====
// Channel   Ports                                           Handshake
// request   start_i, num_in_i, den_in_i                     start_i && !busy_o
// result    valid_o, num_out_o, den_out_o, zero_den_error_o valid_o, one-cycle strobe
//
// A zero denominator is answered straight from idle. Otherwise an item runs
// the binary GCD steps (one shift or subtract-and-shift per cycle), then the
// two exact divisions, which share one bit-serial divider (WIDTH quotient
// bits, then done).
// Reset is asynchronous, active low, and returns the unit to idle. The
// receiver cannot stall: each result shows for exactly one cycle, and a new
// request may be taken in that same cycle.
`default_nettype none

module fraction_reduce_gcd_unit
  import frd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [WIDTH-1:0] num_in_i,
  input  wire logic signed [WIDTH-1:0] den_in_i,
  output logic                         valid_o,
  output logic signed [WIDTH-1:0]      num_out_o,
  output logic signed [WIDTH-1:0]      den_out_o,
  output logic                         zero_den_error_o
);

  localparam int KW = $clog2(WIDTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIVN = 2'd2;
  localparam logic [1:0] S_DIVD = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]    k_q, k_d;
  logic [WIDTH-1:0] mn_q, mn_d, md_q, md_d, g_q, g_d, qn_q, qn_d;
  logic             neg_q, neg_d;
  logic             valid_q, valid_d;
  logic [WIDTH-1:0] num_out_q, num_out_d, den_out_q, den_out_d;
  logic             err_q, err_d;

  logic [WIDTH-1:0] mag_n, mag_d, g_shift;
  logic             div_start;
  logic [WIDTH-1:0] div_dividend, div_divisor, div_quo;
  frd_div_sts_t     div_sts;

  assign mag_n   = num_in_i[WIDTH-1] ? (WIDTH'(0) - num_in_i) : num_in_i;
  assign mag_d   = den_in_i[WIDTH-1] ? (WIDTH'(0) - den_in_i) : den_in_i;
  assign g_shift = b_q << k_q;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    k_d          = k_q;
    mn_d         = mn_q;
    md_d         = md_q;
    g_d          = g_q;
    qn_d         = qn_q;
    neg_d        = neg_q;
    valid_d      = 1'b0;
    num_out_d    = num_out_q;
    den_out_d    = den_out_q;
    err_d        = err_q;
    div_start    = 1'b0;
    div_dividend = mn_q;
    div_divisor  = g_shift;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (den_in_i == '0) begin
            num_out_d = '0;
            den_out_d = '0;
            err_d     = 1'b1;
            valid_d   = 1'b1;
          end else begin
            a_d     = mag_n;
            b_d     = mag_d;
            k_d     = '0;
            mn_d    = mag_n;
            md_d    = mag_d;
            neg_d   = num_in_i[WIDTH-1] ^ den_in_i[WIDTH-1];
            state_d = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (a_q == '0) begin
          // gcd is b scaled by the common twos
          g_d       = g_shift;
          div_start = 1'b1;
          state_d   = S_DIVN;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = (a_q - b_q) >> 1;
        end else begin
          b_d = (b_q - a_q) >> 1;
        end
      end
      S_DIVN: begin
        div_dividend = md_q;
        div_divisor  = g_q;
        if (div_sts.done) begin
          qn_d      = div_quo;
          div_start = 1'b1;
          state_d   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_sts.done) begin
          // zero numerator keeps a plus sign
          num_out_d = (neg_q && qn_q != '0) ? (WIDTH'(0) - qn_q) : qn_q;
          den_out_d = div_quo;
          err_d     = 1'b0;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  frd_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    mn_q      <= mn_d;
    md_q      <= md_d;
    g_q       <= g_d;
    qn_q      <= qn_d;
    neg_q     <= neg_d;
    num_out_q <= num_out_d;
    den_out_q <= den_out_d;
    err_q     <= err_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign num_out_o        = num_out_q;
  assign den_out_o        = den_out_q;
  assign zero_den_error_o = err_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_den_error_o |-> num_out_o == '0 && den_out_o == '0)
    else $error("zero-denominator result not cleared");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_den_error_o |-> den_out_o != '0)
    else $error("reduced denominator is zero");

  a_gcd_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> b_q != '0)
    else $error("gcd operand b dropped to zero");

  a_div_ctx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == S_DIVN || state_q == S_DIVD)
    else $error("divider finished outside a division phase");

  a_div_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> busy_o)
    else $error("divider running while unit idle");

endmodule : fraction_reduce_gcd_unit

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam int RANDOM_REQUESTS = 400;
  localparam int CALM_TAIL = 40;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
  } request_t;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    logic                zero_den;
  } fraction_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic signed [W-1:0] num_in_i = '0;
  logic signed [W-1:0] den_in_i = '0;
  logic                busy_o;
  logic                valid_o;
  logic signed [W-1:0] num_out_o;
  logic signed [W-1:0] den_out_o;
  logic                zero_den_error_o;

  request_t  request_q[$];
  fraction_t lowest_terms_q[$];
  int        mismatches = 0;

  fraction_reduce_gcd_unit #(
    .WIDTH(W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .num_in_i        (num_in_i),
    .den_in_i        (den_in_i),
    .valid_o         (valid_o),
    .num_out_o       (num_out_o),
    .den_out_o       (den_out_o),
    .zero_den_error_o(zero_den_error_o)
  );

  always #1 clk_i = ~clk_i;

  // Euclid on the magnitudes, exact division, then move the sign to the numerator.
  function automatic fraction_t reduce_fraction(logic [W-1:0] num, logic [W-1:0] den);
    fraction_t    r;
    logic [W-1:0] mag_n, mag_d, a, b, rem, q_n, q_d;
    r = '0;
    if (den == '0) begin
      r.zero_den = 1'b1;
    end else begin
      mag_n = num[W-1] ? -num : num;
      mag_d = den[W-1] ? -den : den;
      a = mag_n;
      b = mag_d;
      while (b != '0) begin
        rem = a % b;
        a = b;
        b = rem;
      end
      q_n = mag_n / a;
      q_d = mag_d / a;
      r.num = ((num[W-1] != den[W-1]) && (q_n != '0)) ? -q_n : q_n;
      r.den = q_d;
    end
    return r;
  endfunction

  task automatic add_request(logic [W-1:0] num, logic [W-1:0] den);
    request_q.push_back('{num: num, den: den});
  endtask

  function automatic logic [W-1:0] random_sign(logic [W-1:0] v);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // Driver: hold a request until it is taken or, now and then, withdrawn and put back in line; idle in short bursts.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    request_t    req;
    logic        take;
    logic        calm;
    int unsigned idle_left;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      num_in_i  <= '0;
      den_in_i  <= '0;
      idle_left = 0;
    end else begin
      take = start_i && !busy_o;
      calm = request_q.size() < CALM_TAIL;
      if (take) begin
        lowest_terms_q.push_back(reduce_fraction(num_in_i, den_in_i));
        if (!calm && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 6);
      end else if (start_i && busy_o && !calm && $urandom_range(0, 63) == 0) begin
        // withdraw the waiting request for a while; put it back in line
        request_q.push_front('{num: num_in_i, den: den_in_i});
        idle_left = $urandom_range(1, 6);
      end
      if (idle_left != 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (start_i && !take) begin
        // hold
      end else if (request_q.size() != 0) begin
        req = request_q.pop_front();
        num_in_i <= req.num;
        den_in_i <= req.den;
        start_i  <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check
    fraction_t want;
    if (rst_ni && valid_o) begin
      if (lowest_terms_q.size() == 0) begin
        $display("%0t: unexpected result num %0d den %0d err %0b", $time,
                 num_out_o, den_out_o, zero_den_error_o);
        mismatches++;
      end else begin
        want = lowest_terms_q.pop_front();
        if (num_out_o !== want.num) begin
          $display("%0t: num_out expected %0d actual %0d", $time, want.num, num_out_o);
          mismatches++;
        end
        if (den_out_o !== want.den) begin
          $display("%0t: den_out expected %0d actual %0d", $time, want.den, den_out_o);
          mismatches++;
        end
        if (zero_den_error_o !== want.zero_den) begin
          $display("%0t: zero_den_error expected %0b actual %0b", $time, want.zero_den,
                   zero_den_error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [W-1:0] g, p, q, n, d;
    int unsigned  k;
    // zero denominator
    add_request('0, '0);
    add_request(5, '0);
    add_request(MOST_NEG, '0);
    add_request(-1, '0);
    // zero numerator
    add_request('0, 7);
    add_request('0, -7);
    add_request('0, MOST_NEG);
    // every sign combination
    add_request(6, 4);
    add_request(-6, 4);
    add_request(6, -4);
    add_request(-6, -4);
    // most negative numerator over minus one wraps
    add_request(MOST_NEG, -1);
    add_request(MOST_NEG, 1);
    add_request(MOST_NEG, MOST_NEG);
    // most negative denominator with divisor one wraps
    add_request(1, MOST_NEG);
    add_request(-1, MOST_NEG);
    add_request(3, MOST_NEG);
    add_request(12, MOST_NEG);
    add_request(MOST_POS, MOST_POS);
    add_request(MOST_POS, 1);
    add_request(1, MOST_POS);
    add_request(MOST_POS, MOST_NEG);
    add_request(MOST_NEG, MOST_POS);
    add_request(-1, -1);

    repeat (RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom();
          d = $urandom();
        end
        2, 3, 4: begin
          g = $urandom_range(1, 65535);
          p = $urandom_range(0, 32767);
          q = $urandom_range(1, 32767);
          n = random_sign(g * p);
          d = random_sign(g * q);
        end
        5: begin
          g = $urandom_range(1, 1 << 24);
          p = $urandom_range(0, 127);
          q = $urandom_range(1, 127);
          n = random_sign(g * p);
          d = random_sign(g * q);
        end
        6: begin
          // shared power of two stresses the shift steps
          k = $urandom_range(0, 24);
          n = $urandom() << k;
          d = ($urandom() | 1) << k;
        end
        7: begin
          n = $urandom_range(0, 40) - 20;
          d = $urandom_range(0, 40) - 20;
        end
        8: begin
          d = random_sign($urandom_range(1, 1000));
          n = random_sign(d * $urandom_range(0, 100000));
        end
        default: begin
          case ($urandom_range(0, 5))
            0: n = '0;
            1: n = 1;
            2: n = -1;
            3: n = MOST_NEG;
            4: n = MOST_POS;
            default: n = MOST_NEG + 1;
          endcase
          case ($urandom_range(0, 6))
            0: d = '0;
            1: d = 1;
            2: d = -1;
            3: d = MOST_NEG;
            4: d = MOST_POS;
            5: d = MOST_NEG + 1;
            default: d = $urandom();
          endcase
          if ($urandom_range(0, 1) != 0) begin
            g = n;
            n = d;
            d = g;
          end
        end
      endcase
      add_request(n, d);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start_i || lowest_terms_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lowest_terms_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lowest_terms_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/frd_pkg.sv
sv/frd_div.sv
sv/fraction_reduce_gcd_unit.sv
tb/sv/testbench.sv
